// File: hw/rtl/xcfu_pkg.sv
// Package for the x86 compare flag unit: request/result payload types,
// action codes and small helper functions. No dependencies.
package xcfu_pkg;

  localparam int unsigned DataW = 64;

  typedef enum logic [1:0] {
    ACT_CMP     = 2'd0,
    ACT_TEST    = 2'd1,
    ACT_CMPXCHG = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_WORD  = 2'd1,
    SIZE_DWORD = 2'd2,
    SIZE_QWORD = 2'd3
  } size_t;

  typedef struct packed {
    action_t            action;
    size_t              size_code;
    logic [DataW-1:0]   first_value;
    logic [DataW-1:0]   second_value;
    logic [DataW-1:0]   accumulator_in;
  } req_t;

  typedef struct packed {
    logic               carry_flag;
    logic               zero_flag;
    logic               parity_flag;
    logic               adjust_flag;
    logic               sign_flag;
    logic               overflow_flag;
    logic               write_dest;
    logic [DataW-1:0]   dest_value;
    logic               write_accumulator;
    logic [DataW-1:0]   accumulator_out;
  } rsp_t;

  typedef struct packed {
    logic carry_flag;
    logic zero_flag;
    logic parity_flag;
    logic adjust_flag;
    logic sign_flag;
    logic overflow_flag;
  } flags_t;

  function automatic logic [DataW-1:0] width_mask(input size_t sz);
    logic [DataW-1:0] m;
    case (sz)
      SIZE_BYTE:  m = 64'h0000_0000_0000_00FF;
      SIZE_WORD:  m = 64'h0000_0000_0000_FFFF;
      SIZE_DWORD: m = 64'h0000_0000_FFFF_FFFF;
      default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [DataW-1:0] v, input size_t sz);
    logic b;
    case (sz)
      SIZE_BYTE:  b = v[7];
      SIZE_WORD:  b = v[15];
      SIZE_DWORD: b = v[31];
      default:    b = v[63];
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/xcfu_if.sv
// Valid/ready channel interfaces for the compare flag unit.
// Depends on xcfu_pkg for the payload structs.
interface xcfu_req_if;
  import xcfu_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface xcfu_rsp_if;
  import xcfu_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/x86_compare_flag_unit_top.sv
// Top level of the x86 compare flag unit: input register, datapath, result register.
// Depends on xcfu_pkg, xcfu_if and xcfu_calc.
//
// Usage:
//   req carries one instruction word (action, size code, two operands and the
//   full accumulator); rsp returns one result word with the six arithmetic flags
//   and the destination or accumulator write request.
//   Both channels are valid/ready; a word moves when valid and ready are high
//   at a rising clock edge.
//   The request is captured in an input register at acceptance, and the
//   subtractor and flag logic feed the result register, which drives rsp.
//   Throughput is one word per cycle while the receiver takes results, since
//   each register passes its word on in the same cycle that it takes a new one.
//   When the receiver stalls, the result register holds its word, the input
//   register takes one more word if it is empty, and req.ready then stays low
//   until the result is taken.
//   Synchronous reset (rst, active high) empties both registers; no word is
//   produced across reset and there is no setup period afterwards.
module x86_compare_flag_unit_top
  import xcfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  xcfu_req_if.sink    req,
  xcfu_rsp_if.source  rsp
);

  logic stage_valid;
  req_t stage_data;
  logic out_valid;
  rsp_t out_data;
  rsp_t calc_data;
  logic out_take;

  assign out_take  = !out_valid || rsp.ready;
  assign req.ready = !stage_valid || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_data <= req.data;
    end
  end

  xcfu_calc u_calc (
    .req_data (stage_data),
    .rsp_data (calc_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && stage_valid) begin
      out_data <= calc_data;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // A result never requests both register writes.
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.write_dest && out_data.write_accumulator))
    else $error("both destination and accumulator writes requested");

  // A destination write only follows a match.
  a_match_zf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.write_dest) |-> out_data.zero_flag)
    else $error("destination write without a match");

  // A word waiting in the input register moves on when the result side is free.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && out_take) |=> out_valid)
    else $error("stage word was not passed to the result register");

endmodule

// File: hw/rtl/xcfu_calc.sv
// Combinational compare/test/compare-exchange datapath: one masked subtractor,
// an AND path and the flag gates. Depends on xcfu_pkg.
module xcfu_calc
  import xcfu_pkg::*;
(
  input  req_t req_data,
  output rsp_t rsp_data
);

  logic [DataW-1:0] mask;
  logic [DataW-1:0] op_a;
  logic [DataW-1:0] op_b;
  logic [DataW-1:0] acc_low;
  logic [DataW-1:0] sub_lhs;
  logic [DataW:0]   diff;
  logic [DataW-1:0] sub_res;
  logic [DataW-1:0] and_res;
  flags_t           sub_f;

  assign mask    = width_mask(req_data.size_code);
  assign op_a    = req_data.first_value & mask;
  assign op_b    = req_data.second_value & mask;
  assign acc_low = req_data.accumulator_in & mask;

  // Exchange compares the accumulator against the destination.
  assign sub_lhs = (req_data.action == ACT_CMPXCHG) ? acc_low : op_a;
  assign diff    = {1'b0, sub_lhs} - {1'b0, (req_data.action == ACT_CMPXCHG) ? op_a : op_b};
  assign sub_res = diff[DataW-1:0] & mask;
  assign and_res = op_a & op_b;

  always_comb begin
    logic [DataW-1:0] rhs;
    rhs = (req_data.action == ACT_CMPXCHG) ? op_a : op_b;
    // Operands are masked, so the borrow out of the full word is the unsigned borrow.
    sub_f.carry_flag    = diff[DataW];
    sub_f.zero_flag     = (sub_res == '0);
    sub_f.parity_flag   = ~^sub_res[7:0];
    sub_f.adjust_flag   = sub_lhs[4] ^ rhs[4] ^ sub_res[4];
    sub_f.sign_flag     = top_bit(sub_res, req_data.size_code);
    sub_f.overflow_flag = top_bit((sub_lhs ^ rhs) & (sub_lhs ^ sub_res), req_data.size_code);
  end

  always_comb begin
    rsp_data = '0;
    case (req_data.action)
      ACT_CMP: begin
        rsp_data.carry_flag    = sub_f.carry_flag;
        rsp_data.zero_flag     = sub_f.zero_flag;
        rsp_data.parity_flag   = sub_f.parity_flag;
        rsp_data.adjust_flag   = sub_f.adjust_flag;
        rsp_data.sign_flag     = sub_f.sign_flag;
        rsp_data.overflow_flag = sub_f.overflow_flag;
      end
      ACT_TEST: begin
        rsp_data.zero_flag   = (and_res == '0);
        rsp_data.parity_flag = ~^and_res[7:0];
        rsp_data.sign_flag   = top_bit(and_res, req_data.size_code);
      end
      ACT_CMPXCHG: begin
        rsp_data.carry_flag    = sub_f.carry_flag;
        rsp_data.zero_flag     = sub_f.zero_flag;
        rsp_data.parity_flag   = sub_f.parity_flag;
        rsp_data.adjust_flag   = sub_f.adjust_flag;
        rsp_data.sign_flag     = sub_f.sign_flag;
        rsp_data.overflow_flag = sub_f.overflow_flag;
        if (sub_f.zero_flag) begin
          rsp_data.write_dest = 1'b1;
          rsp_data.dest_value = op_b;
        end else begin
          rsp_data.write_accumulator = 1'b1;
          rsp_data.accumulator_out   = (req_data.accumulator_in & ~mask) | op_a;
        end
      end
      default: begin
        rsp_data = '0;
      end
    endcase
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for x86_compare_flag_unit_top: directed table plus random words,
// with a flag predictor and random stalls on both valid/ready channels.
// Depends on xcfu_pkg, xcfu_if and the RTL of the unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xcfu_pkg::*;

  // Action code 3 has no enum member; the unit must treat it as a no-op.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int unsigned RANDOM_WORDS = 633;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct {
    req_t word;
    bit   typed;
    rsp_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  xcfu_req_if req_ch ();
  xcfu_rsp_if rsp_ch ();

  x86_compare_flag_unit_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #4 clk = ~clk;

  rsp_t        expected_flag_words[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned cmp_words = 0;
  int unsigned test_words = 0;
  int unsigned xchg_hits = 0;
  int unsigned xchg_misses = 0;
  int unsigned spare_words = 0;
  bit          sender_quiet = 1'b0;

  function automatic logic [63:0] size_mask(input size_t sz);
    case (sz)
      SIZE_BYTE:  return 64'h0000_0000_0000_00FF;
      SIZE_WORD:  return 64'h0000_0000_0000_FFFF;
      SIZE_DWORD: return 64'h0000_0000_FFFF_FFFF;
      default:    return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  function automatic int size_msb(input size_t sz);
    case (sz)
      SIZE_BYTE:  return 7;
      SIZE_WORD:  return 15;
      SIZE_DWORD: return 31;
      default:    return 63;
    endcase
  endfunction

  // Flags of minuend - subtrahend; both operands are already masked.
  function automatic flags_t borrow_flags(input logic [63:0] minuend, input logic [63:0] subtrahend,
                                          input int msb, input logic [63:0] m);
    flags_t      f;
    logic [63:0] diff;
    logic [63:0] carries;
    logic [63:0] ovf;
    diff = (minuend - subtrahend) & m;
    carries = minuend ^ subtrahend ^ diff;
    ovf = (minuend ^ subtrahend) & (minuend ^ diff);
    f.carry_flag = (minuend < subtrahend);
    f.zero_flag = (diff == 64'd0);
    f.parity_flag = ~^diff[7:0];
    f.adjust_flag = carries[4];
    f.sign_flag = diff[msb];
    f.overflow_flag = ovf[msb];
    return f;
  endfunction

  function automatic rsp_t predict_flag_word(input req_t w);
    rsp_t        r;
    flags_t      f;
    logic [63:0] m;
    logic [63:0] dst;
    logic [63:0] src;
    logic [63:0] acc_low;
    logic [63:0] anded;
    int          msb;
    m = size_mask(w.size_code);
    msb = size_msb(w.size_code);
    dst = w.first_value & m;
    src = w.second_value & m;
    acc_low = w.accumulator_in & m;
    r = '0;
    f = '0;
    case (w.action)
      ACT_CMP: begin
        f = borrow_flags(dst, src, msb, m);
      end
      ACT_TEST: begin
        anded = dst & src;
        f.zero_flag = (anded == 64'd0);
        f.parity_flag = ~^anded[7:0];
        f.sign_flag = anded[msb];
      end
      ACT_CMPXCHG: begin
        f = borrow_flags(acc_low, dst, msb, m);
        if (acc_low == dst) begin
          r.write_dest = 1'b1;
          r.dest_value = src;
        end else begin
          r.write_accumulator = 1'b1;
          r.accumulator_out = (w.accumulator_in & ~m) | dst;
        end
      end
      default: ;
    endcase
    {r.carry_flag, r.zero_flag, r.parity_flag, r.adjust_flag, r.sign_flag,
     r.overflow_flag} = f;
    return r;
  endfunction

  function automatic logic [63:0] random_operand();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      4:       return 64'hFFFF_FFFF_8000_8080;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic req_t random_word();
    req_t        w;
    logic [63:0] m;
    if ($urandom_range(0, 99) < 3) w.action = action_t'(ACT_SPARE);
    else w.action = action_t'($urandom_range(0, 2));
    w.size_code = size_t'($urandom_range(0, 3));
    w.first_value = random_operand();
    w.second_value = random_operand();
    w.accumulator_in = random_operand();
    m = size_mask(w.size_code);
    // Equal operands at the active width, so zero results show up often.
    if ($urandom_range(0, 3) == 0)
      w.second_value = (w.second_value & ~m) | (w.first_value & m);
    if (w.action == ACT_CMPXCHG && $urandom_range(0, 1) == 0)
      w.accumulator_in = (w.accumulator_in & ~m) | (w.first_value & m);
    return w;
  endfunction

  function automatic int unsigned idle_cycles(input bit quiet);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (quiet || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_row(input action_t act, input size_t sz, input logic [63:0] first,
                         input logic [63:0] second, input logic [63:0] acc,
                         input bit typed, input rsp_t result);
    stim_row_t row;
    row.word = '{act, sz, first, second, acc};
    row.typed = typed;
    row.result = result;
    directed_rows.push_back(row);
  endtask

  // Drives one word and returns at the edge where it is accepted.
  task automatic send_word(input req_t w, input bit typed, input rsp_t typed_result);
    int unsigned gap;
    rsp_t        predicted;
    gap = idle_cycles(sender_quiet);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = predict_flag_word(w);
    expected_flag_words.push_back(typed ? typed_result : predicted);
    case (w.action)
      ACT_CMP:     cmp_words++;
      ACT_TEST:    test_words++;
      ACT_CMPXCHG: if (predicted.write_dest) xchg_hits++; else xchg_misses++;
      default:     spare_words++;
    endcase
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_flag_words.size() != 0);
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Result word %0d: %s is %h, expected %h", results_seen, field, got, want);
    end
  endtask

  initial begin
    req_t        w;
    int unsigned n;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    rst <= 1'b1;

    // Typed results list the flags as CF ZF PF AF SF OF, then the two write requests.
    add_row(ACT_CMP, SIZE_BYTE, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
            rsp_t'({6'b011000, 1'b0, 64'h0, 1'b0, 64'h0}));
    add_row(ACT_CMP, SIZE_BYTE, 64'h0, 64'h1, 64'h0, 1'b1,
            rsp_t'({6'b101110, 1'b0, 64'h0, 1'b0, 64'h0}));
    add_row(ACT_CMP, SIZE_BYTE, 64'h80, 64'h1, 64'h0, 1'b1,
            rsp_t'({6'b000101, 1'b0, 64'h0, 1'b0, 64'h0}));
    add_row(ACT_CMP, SIZE_BYTE, 64'hFFFF_FFFF_FFFF_FF05, 64'h1234_5678_9ABC_DE05, 64'h0, 1'b1,
            rsp_t'({6'b011000, 1'b0, 64'h0, 1'b0, 64'h0}));
    add_row(ACT_CMP, SIZE_WORD, 64'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, '0);
    add_row(ACT_CMP, SIZE_DWORD, 64'hFFFF_FFFF_0000_0000, 64'h1, 64'h0, 1'b0, '0);
    add_row(ACT_CMP, SIZE_QWORD, 64'h8000_0000_0000_0000, 64'h1, 64'h0, 1'b0, '0);
    add_row(ACT_CMP, SIZE_QWORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1,
            rsp_t'({6'b011000, 1'b0, 64'h0, 1'b0, 64'h0}));
    add_row(ACT_CMP, SIZE_QWORD, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, '0);
    add_row(ACT_TEST, SIZE_QWORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1,
            rsp_t'({6'b001010, 1'b0, 64'h0, 1'b0, 64'h0}));
    add_row(ACT_TEST, SIZE_BYTE, 64'hFF00, 64'hFF00, 64'h0, 1'b1,
            rsp_t'({6'b011000, 1'b0, 64'h0, 1'b0, 64'h0}));
    add_row(ACT_TEST, SIZE_WORD, 64'h8001, 64'hF0F1, 64'h0, 1'b0, '0);
    add_row(ACT_TEST, SIZE_DWORD, 64'h1357_9BDF_8642_0ACE, 64'hF0F0_F0F0_F0F0_F0F0, 64'h0,
            1'b0, '0);
    add_row(ACT_CMPXCHG, SIZE_BYTE, 64'hAAAA_AAAA_AAAA_AA12, 64'hFFFF_FFFF_FFFF_ABCD,
            64'hFFFF_FFFF_FFFF_FF12, 1'b1, rsp_t'({6'b011000, 1'b1, 64'hCD, 1'b0, 64'h0}));
    add_row(ACT_CMPXCHG, SIZE_QWORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5, 64'h0, 1'b0, '0);
    add_row(ACT_CMPXCHG, SIZE_DWORD, 64'h0000_0005_0000_0002, 64'h1234, 64'hDEAD_BEEF_0000_0001,
            1'b1, rsp_t'({6'b101110, 1'b0, 64'h0, 1'b1, 64'hDEAD_BEEF_0000_0002}));
    add_row(ACT_CMPXCHG, SIZE_WORD, 64'h9999_8000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h1111_2222_3333_8000, 1'b0, '0);
    add_row(ACT_CMPXCHG, SIZE_QWORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
            64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0);
    add_row(action_t'(ACT_SPARE), SIZE_QWORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0);
    add_row(action_t'(ACT_SPARE), SIZE_BYTE, 64'h0, 64'h0, 64'h0, 1'b1, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
    wait_all_results();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      // Some stretches run back to back with no gaps from the sender.
      if (n % 60 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) wait_all_results();
      w = random_word();
      send_word(w, 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    while (expected_flag_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words: %0d compare, %0d test, %0d exchange hits, %0d misses,",
             results_seen, cmp_words, test_words, xchg_hits, xchg_misses);
    $display("%0d with the unused action code; all operand sizes, stalls on both sides.",
             spare_words);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: ready toggles with random stall lengths and occasional long open runs.
  initial begin
    int unsigned run;
    int unsigned stall;
    rsp_ch.ready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 15) == 0) ? 80 : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      stall = idle_cycles(1'b0);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (expected_flag_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Result word %0d arrived with nothing expected: %h", results_seen,
                   rsp_ch.data);
      end else begin
        want = expected_flag_words.pop_front();
        check_field("carry_flag", 64'(rsp_ch.data.carry_flag), 64'(want.carry_flag));
        check_field("zero_flag", 64'(rsp_ch.data.zero_flag), 64'(want.zero_flag));
        check_field("parity_flag", 64'(rsp_ch.data.parity_flag), 64'(want.parity_flag));
        check_field("adjust_flag", 64'(rsp_ch.data.adjust_flag), 64'(want.adjust_flag));
        check_field("sign_flag", 64'(rsp_ch.data.sign_flag), 64'(want.sign_flag));
        check_field("overflow_flag", 64'(rsp_ch.data.overflow_flag), 64'(want.overflow_flag));
        check_field("write_dest", 64'(rsp_ch.data.write_dest), 64'(want.write_dest));
        check_field("dest_value", rsp_ch.data.dest_value, want.dest_value);
        check_field("write_accumulator", 64'(rsp_ch.data.write_accumulator),
                    64'(want.write_accumulator));
        check_field("accumulator_out", rsp_ch.data.accumulator_out, want.accumulator_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result words outstanding", cycle_count,
               expected_flag_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// File: sim.f
hw/rtl/xcfu_pkg.sv
hw/rtl/xcfu_if.sv
hw/rtl/xcfu_calc.sv
hw/rtl/x86_compare_flag_unit_top.sv
tb/tb_top.sv
